// ===== rtl/modular_combinatorics_unit_core_macros.svh =====
// Assertion macros used by the core top level to check its own logic.
`ifndef MODULAR_COMBINATORICS_UNIT_CORE_MACROS_SVH
`define MODULAR_COMBINATORICS_UNIT_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mcu_pkg.sv =====
package mcu_pkg;

  localparam int RES_W = 13;
  localparam logic [RES_W-1:0] MOD = 13'd7901;
  localparam logic [19:0] MOD_RECIP = 20'((64'd1 << 32) / 64'(MOD));
  localparam logic [31:0] EXP_INV = 32'(MOD) - 32'd2;

  localparam logic [2:0] OP_POWER       = 3'd0;
  localparam logic [2:0] OP_CHOOSE      = 3'd1;
  localparam logic [2:0] OP_ARRANGE     = 3'd2;
  localparam logic [2:0] OP_CATALAN     = 3'd3;
  localparam logic [2:0] OP_DERANGEMENT = 3'd4;
  localparam logic [2:0] OP_FACTORIAL   = 3'd5;

  typedef enum logic [1:0] {A_ACC, A_OPB, A_IDX} a_sel_t;
  typedef enum logic [2:0] {B_OPB, B_IDX, B_SUM, B_FACT, B_INV, B_DER} b_sel_t;
  typedef enum logic [1:0] {DST_ACC, DST_OPB, DST_DER} dst_t;
  typedef enum logic [1:0] {RA_N, RA_R, RA_NMR, RA_TWON} raddr_sel_t;
  typedef enum logic [1:0] {WA_IDX, WA_DEC, WA_INC} waddr_sel_t;

  typedef struct packed {
    logic       mul_start;
    logic       mul_raw;
    a_sel_t     a_sel;
    b_sel_t     b_sel;
    dst_t       dst;
    logic       acc_one;
    logic       acc_zero;
    logic       opb_acc;
    logic       opb_np1;
    logic       expo_inv;
    logic       expo_shift;
    logic       req_ld;
    logic       idx_inc;
    logic       idx_dec;
    logic       d_init;
    raddr_sel_t raddr_sel;
    logic       we_fact;
    logic       we_inv;
    logic       we_der;
    waddr_sel_t waddr_sel;
    logic       wdata_d1;
    logic       out_ld;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic expo_zero;
    logic expo_lsb;
    logic expo_hi_zero;
    logic idx_last;
    logic idx_one;
    logic idx_p1_last;
    logic ok_nr;
    logic ok_cat;
    logic ok_idx;
  } dp_status_t;

endpackage

// ===== rtl/modular_combinatorics_unit_core.sv =====
// Combinatorial residues modulo the prime 7901.
// Requests enter on the in_valid/in_ready channel with an opcode and its
// operands; each request gives exactly one residue on out_valid/out_ready.
// After reset the block fills its factorial, inverse factorial and
// derangement tables one entry at a time through the shared modular
// multiplier, plus an exponentiation for the top inverse entry, with
// in_ready low. A request offered during that time simply waits.
// Every modular product goes through the three-stage multiplier.
// Table operations multiply the accumulator by one table entry per step:
// factorial and derangement use one entry, arrange two, choose three.
// Power first reduces the base, then runs square-and-multiply over the
// exponent bits. Catalan multiplies three table entries after an
// exponentiation for the inverse of n + 1. Invalid operands answer zero.
// One request is worked on at a time. A finished result waits in the output
// register while out_ready is low; the next request may already be accepted
// and is held back only at its own finish until the output is free.
`include "modular_combinatorics_unit_core_macros.svh"

module modular_combinatorics_unit_core #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                opcode,
  input  logic [31:0]               power_base,
  input  logic [31:0]               power_exponent,
  input  logic signed [15:0]        count_n,
  input  logic signed [15:0]        choose_r,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mcu_pkg::RES_W-1:0] residue
);
  import mcu_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mcu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mcu_datapath #(.TABLE_SIZE(TABLE_SIZE)) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .power_base     (power_base),
    .power_exponent (power_exponent),
    .count_n        (count_n),
    .choose_r       (choose_r),
    .status         (status),
    .residue        (residue)
  );

  `MCU_ASSERT_SAME(a_residue_range, out_valid, residue < MOD, "residue not reduced")
  `MCU_ASSERT_SAME(a_no_overwrite, cmd.out_ld, !out_valid || out_ready, "result overwritten")
  `MCU_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second item taken")
  `MCU_ASSERT_SAME(a_mul_idle_start, cmd.mul_start, !status.mul_done, "multiplier overlap")

endmodule

// ===== rtl/mcu_ram.sv =====
module mcu_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mcu_modmul.sv =====
module mcu_modmul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       raw_ld,
  input  logic [mcu_pkg::RES_W-1:0]  a,
  input  logic [mcu_pkg::RES_W-1:0]  b,
  input  logic [31:0]                raw,
  output logic                       done,
  output logic [mcu_pkg::RES_W-1:0]  res
);
  import mcu_pkg::*;

  logic                 v1;
  logic                 v2;
  logic [2*RES_W-1:0]   ab;
  logic [31:0]          prod;
  logic [31:0]          prod2;
  logic [51:0]          qfull;
  logic [19:0]          quo;
  logic [32:0]          qm;
  logic [31:0]          diff;
  logic [RES_W:0]       rem;

  // The quotient estimate from the reciprocal is low by at most one, so the
  // remainder stays below twice the modulus and one subtraction corrects it.
  assign ab    = a * b;
  assign qfull = {20'd0, prod} * {32'd0, MOD_RECIP};
  assign qm    = {13'd0, quo} * {20'd0, MOD};
  assign diff  = prod2 - qm[31:0];
  assign rem   = diff[RES_W:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= raw_ld ? raw : 32'(ab);
    end
    if (v1) begin
      quo   <= qfull[51:32];
      prod2 <= prod;
    end
    if (v2) begin
      res <= (rem >= {1'b0, MOD}) ? RES_W'(rem - {1'b0, MOD}) : rem[RES_W-1:0];
    end
  end

endmodule

// ===== rtl/mcu_datapath.sv =====
module mcu_datapath #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mcu_pkg::ctrl_cmd_t        cmd,
  input  logic [31:0]               power_base,
  input  logic [31:0]               power_exponent,
  input  logic signed [15:0]        count_n,
  input  logic signed [15:0]        choose_r,
  output mcu_pkg::dp_status_t       status,
  output logic [mcu_pkg::RES_W-1:0] residue
);
  import mcu_pkg::*;

  localparam int AW = $clog2(TABLE_SIZE);
  localparam logic signed [17:0] T_S = 18'(TABLE_SIZE);

  logic [AW-1:0]            idx;
  logic [AW:0]              idx_p1;
  logic [RES_W-1:0]         acc;
  logic [RES_W-1:0]         opb;
  logic [RES_W-1:0]         d1;
  logic [RES_W-1:0]         d2;
  logic [31:0]              expo;
  logic [31:0]              base_reg;
  logic signed [15:0]       n_reg;
  logic signed [15:0]       r_reg;
  dst_t                     dst_reg;
  logic signed [17:0]       n_ext;
  logic signed [17:0]       r_ext;
  logic signed [17:0]       two_n;
  logic [15:0]              nmr;
  logic [RES_W:0]           draw;
  logic [RES_W-1:0]         dsum;
  logic [RES_W-1:0]         op_a;
  logic [RES_W-1:0]         op_b;
  logic                     mul_done;
  logic [RES_W-1:0]         mul_res;
  logic [AW-1:0]            waddr;
  logic [AW-1:0]            raddr;
  logic [RES_W-1:0]         wdata;
  logic [RES_W-1:0]         fact_rd;
  logic [RES_W-1:0]         inv_rd;
  logic [RES_W-1:0]         der_rd;

  assign n_ext  = {{2{n_reg[15]}}, n_reg};
  assign r_ext  = {{2{r_reg[15]}}, r_reg};
  assign two_n  = {n_ext[16:0], 1'b0};
  assign nmr    = n_reg - r_reg;
  assign idx_p1 = {1'b0, idx} + (AW+1)'(1);

  assign draw = {1'b0, d1} + {1'b0, d2};
  assign dsum = (draw >= {1'b0, MOD}) ? RES_W'(draw - {1'b0, MOD}) : draw[RES_W-1:0];

  always_comb begin
    unique case (cmd.a_sel)
      A_ACC:   op_a = acc;
      A_OPB:   op_a = opb;
      A_IDX:   op_a = RES_W'(idx);
      default: op_a = acc;
    endcase
    unique case (cmd.b_sel)
      B_OPB:   op_b = opb;
      B_IDX:   op_b = RES_W'(idx);
      B_SUM:   op_b = dsum;
      B_FACT:  op_b = fact_rd;
      B_INV:   op_b = inv_rd;
      B_DER:   op_b = der_rd;
      default: op_b = '0;
    endcase
    unique case (cmd.waddr_sel)
      WA_IDX:  waddr = idx;
      WA_DEC:  waddr = idx - AW'(1);
      WA_INC:  waddr = idx_p1[AW-1:0];
      default: waddr = idx;
    endcase
    unique case (cmd.raddr_sel)
      RA_N:    raddr = n_reg[AW-1:0];
      RA_R:    raddr = r_reg[AW-1:0];
      RA_NMR:  raddr = nmr[AW-1:0];
      RA_TWON: raddr = two_n[AW-1:0];
      default: raddr = n_reg[AW-1:0];
    endcase
  end

  assign wdata = cmd.wdata_d1 ? d1 : acc;

  mcu_modmul u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .raw_ld (cmd.mul_raw),
    .a      (op_a),
    .b      (op_b),
    .raw    (base_reg),
    .done   (mul_done),
    .res    (mul_res)
  );

  mcu_ram #(.WIDTH(RES_W), .DEPTH(TABLE_SIZE)) u_fact_ram (
    .clk   (clk),
    .we    (cmd.we_fact),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (fact_rd)
  );

  mcu_ram #(.WIDTH(RES_W), .DEPTH(TABLE_SIZE)) u_inv_ram (
    .clk   (clk),
    .we    (cmd.we_inv),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (inv_rd)
  );

  mcu_ram #(.WIDTH(RES_W), .DEPTH(TABLE_SIZE)) u_der_ram (
    .clk   (clk),
    .we    (cmd.we_der),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (der_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx_p1[AW-1:0];
    end else if (cmd.idx_dec) begin
      idx <= idx - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_ld) begin
      base_reg <= power_base;
      n_reg    <= count_n;
      r_reg    <= choose_r;
    end
    if (cmd.mul_start) begin
      dst_reg <= cmd.dst;
    end
    if (cmd.expo_inv) begin
      expo <= EXP_INV;
    end else if (cmd.req_ld) begin
      expo <= power_exponent;
    end else if (cmd.expo_shift) begin
      expo <= expo >> 1;
    end
    if (cmd.opb_acc) begin
      opb <= acc;
    end else if (cmd.opb_np1) begin
      opb <= n_reg[RES_W-1:0] + RES_W'(1);
    end else if (mul_done && dst_reg == DST_OPB) begin
      opb <= mul_res;
    end
    if (cmd.acc_one) begin
      acc <= RES_W'(1);
    end else if (cmd.acc_zero) begin
      acc <= '0;
    end else if (mul_done && dst_reg != DST_OPB) begin
      acc <= mul_res;
    end
    if (cmd.d_init) begin
      d2 <= RES_W'(1);
      d1 <= '0;
    end else if (mul_done && dst_reg == DST_DER) begin
      d2 <= d1;
      d1 <= mul_res;
    end
    if (cmd.out_ld) begin
      residue <= acc;
    end
  end

  assign status.mul_done     = mul_done;
  assign status.expo_zero    = (expo == '0);
  assign status.expo_lsb     = expo[0];
  assign status.expo_hi_zero = (expo[31:1] == '0);
  assign status.idx_last     = (idx == AW'(TABLE_SIZE - 1));
  assign status.idx_one      = (idx == AW'(1));
  assign status.idx_p1_last  = (idx_p1 == (AW+1)'(TABLE_SIZE - 1));
  assign status.ok_nr        = !r_reg[15] && (r_ext <= n_ext) && (n_ext < T_S);
  assign status.ok_cat       = !n_reg[15] && (two_n < T_S);
  assign status.ok_idx       = !n_reg[15] && (n_ext < T_S);

endmodule

// ===== rtl/mcu_ctrl.sv =====
module mcu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          opcode,
  output logic                out_valid,
  input  logic                out_ready,
  input  mcu_pkg::dp_status_t status,
  output mcu_pkg::ctrl_cmd_t  cmd
);
  import mcu_pkg::*;

  localparam logic [4:0] S_BOOT   = 5'd0;
  localparam logic [4:0] S_F0     = 5'd1;
  localparam logic [4:0] S_D1     = 5'd2;
  localparam logic [4:0] S_FMUL   = 5'd3;
  localparam logic [4:0] S_FWAIT  = 5'd4;
  localparam logic [4:0] S_FWR    = 5'd5;
  localparam logic [4:0] S_IPREP  = 5'd6;
  localparam logic [4:0] S_PCHK   = 5'd7;
  localparam logic [4:0] S_PWAIT1 = 5'd8;
  localparam logic [4:0] S_PSQ    = 5'd9;
  localparam logic [4:0] S_PWAIT2 = 5'd10;
  localparam logic [4:0] S_IWR    = 5'd11;
  localparam logic [4:0] S_IMUL   = 5'd12;
  localparam logic [4:0] S_IWAIT  = 5'd13;
  localparam logic [4:0] S_IWR2   = 5'd14;
  localparam logic [4:0] S_DMUL   = 5'd15;
  localparam logic [4:0] S_DWAIT  = 5'd16;
  localparam logic [4:0] S_DWR    = 5'd17;
  localparam logic [4:0] S_IDLE   = 5'd18;
  localparam logic [4:0] S_DISP   = 5'd19;
  localparam logic [4:0] S_BWAIT  = 5'd20;
  localparam logic [4:0] S_TRD    = 5'd21;
  localparam logic [4:0] S_TMUL   = 5'd22;
  localparam logic [4:0] S_TWAIT  = 5'd23;
  localparam logic [4:0] S_ZERO   = 5'd24;
  localparam logic [4:0] S_FIN    = 5'd25;

  localparam logic [1:0] RET_BUILD = 2'd0;
  localparam logic [1:0] RET_QUERY = 2'd1;
  localparam logic [1:0] RET_CAT   = 2'd2;

  logic [4:0]  state;
  logic [4:0]  state_next;
  logic [2:0]  op_reg;
  logic [2:0]  op_next;
  logic [1:0]  ret;
  logic [1:0]  ret_next;
  logic [1:0]  step;
  logic [1:0]  step_next;
  raddr_sel_t  step_addr;
  b_sel_t      step_tbl;
  logic        step_last;

  // Each table operation multiplies the accumulator by a short list of
  // table entries.
  always_comb begin
    step_addr = RA_N;
    step_tbl  = B_FACT;
    step_last = 1'b1;
    unique case (op_reg)
      OP_CHOOSE: begin
        step_last = (step == 2'd2);
        unique case (step)
          2'd0:    begin step_addr = RA_N;   step_tbl = B_FACT; end
          2'd1:    begin step_addr = RA_R;   step_tbl = B_INV;  end
          default: begin step_addr = RA_NMR; step_tbl = B_INV;  end
        endcase
      end
      OP_ARRANGE: begin
        step_last = (step == 2'd1);
        if (step == 2'd0) begin
          step_addr = RA_N;
          step_tbl  = B_FACT;
        end else begin
          step_addr = RA_NMR;
          step_tbl  = B_INV;
        end
      end
      OP_CATALAN: begin
        step_last = (step == 2'd2);
        if (step == 2'd0) begin
          step_addr = RA_TWON;
          step_tbl  = B_FACT;
        end else begin
          step_addr = RA_N;
          step_tbl  = B_INV;
        end
      end
      OP_DERANGEMENT: begin
        step_addr = RA_N;
        step_tbl  = B_DER;
      end
      default: begin
        step_addr = RA_N;
        step_tbl  = B_FACT;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    op_next    = op_reg;
    ret_next   = ret;
    step_next  = step;
    in_ready   = 1'b0;
    unique case (state)
      S_BOOT: begin
        cmd.acc_one = 1'b1;
        state_next  = S_F0;
      end
      S_F0: begin
        cmd.we_fact   = 1'b1;
        cmd.we_der    = 1'b1;
        cmd.waddr_sel = WA_IDX;
        cmd.d_init    = 1'b1;
        cmd.idx_inc   = 1'b1;
        state_next    = S_D1;
      end
      S_D1: begin
        cmd.we_der    = 1'b1;
        cmd.waddr_sel = WA_IDX;
        cmd.wdata_d1  = 1'b1;
        state_next    = S_FMUL;
      end
      S_FMUL: begin
        cmd.mul_start = 1'b1;
        cmd.a_sel     = A_ACC;
        cmd.b_sel     = B_IDX;
        cmd.dst       = DST_ACC;
        state_next    = S_FWAIT;
      end
      S_FWAIT: begin
        if (status.mul_done) begin
          state_next = S_FWR;
        end
      end
      S_FWR: begin
        cmd.we_fact   = 1'b1;
        cmd.waddr_sel = WA_IDX;
        if (status.idx_last) begin
          state_next = S_IPREP;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_FMUL;
        end
      end
      S_IPREP: begin
        cmd.opb_acc  = 1'b1;
        cmd.acc_one  = 1'b1;
        cmd.expo_inv = 1'b1;
        ret_next     = RET_BUILD;
        state_next   = S_PCHK;
      end
      S_PCHK: begin
        if (status.expo_zero) begin
          unique case (ret)
            RET_BUILD: state_next = S_IWR;
            RET_CAT: begin
              step_next  = 2'd0;
              state_next = S_TRD;
            end
            default: state_next = S_FIN;
          endcase
        end else if (status.expo_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.a_sel     = A_ACC;
          cmd.b_sel     = B_OPB;
          cmd.dst       = DST_ACC;
          state_next    = S_PWAIT1;
        end else begin
          state_next = S_PSQ;
        end
      end
      S_PWAIT1: begin
        if (status.mul_done) begin
          state_next = S_PSQ;
        end
      end
      S_PSQ: begin
        cmd.expo_shift = 1'b1;
        if (status.expo_hi_zero) begin
          state_next = S_PCHK;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.a_sel     = A_OPB;
          cmd.b_sel     = B_OPB;
          cmd.dst       = DST_OPB;
          state_next    = S_PWAIT2;
        end
      end
      S_PWAIT2: begin
        if (status.mul_done) begin
          state_next = S_PCHK;
        end
      end
      S_IWR: begin
        cmd.we_inv    = 1'b1;
        cmd.waddr_sel = WA_IDX;
        state_next    = S_IMUL;
      end
      S_IMUL: begin
        cmd.mul_start = 1'b1;
        cmd.a_sel     = A_ACC;
        cmd.b_sel     = B_IDX;
        cmd.dst       = DST_ACC;
        state_next    = S_IWAIT;
      end
      S_IWAIT: begin
        if (status.mul_done) begin
          state_next = S_IWR2;
        end
      end
      S_IWR2: begin
        cmd.we_inv    = 1'b1;
        cmd.waddr_sel = WA_DEC;
        if (status.idx_one) begin
          state_next = status.idx_last ? S_IDLE : S_DMUL;
        end else begin
          cmd.idx_dec = 1'b1;
          state_next  = S_IMUL;
        end
      end
      S_DMUL: begin
        cmd.mul_start = 1'b1;
        cmd.a_sel     = A_IDX;
        cmd.b_sel     = B_SUM;
        cmd.dst       = DST_DER;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (status.mul_done) begin
          state_next = S_DWR;
        end
      end
      S_DWR: begin
        cmd.we_der    = 1'b1;
        cmd.waddr_sel = WA_INC;
        if (status.idx_p1_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_DMUL;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.req_ld = 1'b1;
          op_next    = opcode;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        step_next = 2'd0;
        unique case (op_reg)
          OP_POWER: begin
            cmd.mul_start = 1'b1;
            cmd.mul_raw   = 1'b1;
            cmd.dst       = DST_OPB;
            cmd.acc_one   = 1'b1;
            ret_next      = RET_QUERY;
            state_next    = S_BWAIT;
          end
          OP_CHOOSE, OP_ARRANGE: begin
            cmd.acc_one = status.ok_nr;
            state_next  = status.ok_nr ? S_TRD : S_ZERO;
          end
          OP_CATALAN: begin
            if (status.ok_cat) begin
              cmd.opb_np1  = 1'b1;
              cmd.acc_one  = 1'b1;
              cmd.expo_inv = 1'b1;
              ret_next     = RET_CAT;
              state_next   = S_PCHK;
            end else begin
              state_next = S_ZERO;
            end
          end
          OP_DERANGEMENT, OP_FACTORIAL: begin
            cmd.acc_one = status.ok_idx;
            state_next  = status.ok_idx ? S_TRD : S_ZERO;
          end
          default: state_next = S_ZERO;
        endcase
      end
      S_BWAIT: begin
        if (status.mul_done) begin
          state_next = S_PCHK;
        end
      end
      S_TRD: begin
        cmd.raddr_sel = step_addr;
        state_next    = S_TMUL;
      end
      S_TMUL: begin
        cmd.mul_start = 1'b1;
        cmd.a_sel     = A_ACC;
        cmd.b_sel     = step_tbl;
        cmd.dst       = DST_ACC;
        state_next    = S_TWAIT;
      end
      S_TWAIT: begin
        if (status.mul_done) begin
          if (step_last) begin
            state_next = S_FIN;
          end else begin
            step_next  = step + 2'd1;
            state_next = S_TRD;
          end
        end
      end
      S_ZERO: begin
        cmd.acc_zero = 1'b1;
        state_next   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_BOOT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_BOOT;
      op_reg    <= OP_POWER;
      ret       <= RET_BUILD;
      step      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      op_reg <= op_next;
      ret    <= ret_next;
      step   <= step_next;
      if (cmd.out_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int TBL_DEPTH = 1024;
  localparam int unsigned PRIME = mcu_pkg::MOD;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CALM_FROM = 900;
  localparam int CALM_TO = 1250;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 400;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0]         op;
    logic [31:0]        base;
    logic [31:0]        expo;
    logic signed [15:0] n;
    logic signed [15:0] r;
    bit                 await_drain;
  } request_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [2:0]                opcode = '0;
  logic [31:0]               power_base = '0;
  logic [31:0]               power_exponent = '0;
  logic signed [15:0]        count_n = '0;
  logic signed [15:0]        choose_r = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [mcu_pkg::RES_W-1:0] residue;

  int unsigned fact_tab [TBL_DEPTH];
  int unsigned inv_fact_tab [TBL_DEPTH];
  int unsigned der_tab [TBL_DEPTH];

  request_t                  request_q [$];
  logic [mcu_pkg::RES_W-1:0] residue_expected_q [$];
  int                        accepted_count = 0;
  int                        results_seen = 0;
  int                        errors = 0;
  int unsigned               cycle_count = 0;

  modular_combinatorics_unit_core #(.TABLE_SIZE(TBL_DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .power_base(power_base),
    .power_exponent(power_exponent),
    .count_n(count_n),
    .choose_r(choose_r),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .residue(residue)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int unsigned mod_power(int unsigned b, int unsigned e);
    int unsigned acc;
    acc = 1;
    b = b % PRIME;
    while (e != 0) begin
      if (e[0]) acc = (acc * b) % PRIME;
      b = (b * b) % PRIME;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic void build_residue_tables();
    fact_tab[0] = 1;
    for (int i = 1; i < TBL_DEPTH; i++) fact_tab[i] = (fact_tab[i-1] * i) % PRIME;
    inv_fact_tab[TBL_DEPTH-1] = mod_power(fact_tab[TBL_DEPTH-1], PRIME - 2);
    for (int i = TBL_DEPTH - 2; i >= 0; i--)
      inv_fact_tab[i] = (inv_fact_tab[i+1] * (i + 1)) % PRIME;
    der_tab[0] = 1;
    der_tab[1] = 0;
    for (int i = 2; i < TBL_DEPTH; i++)
      der_tab[i] = ((i - 1) * ((der_tab[i-1] + der_tab[i-2]) % PRIME)) % PRIME;
  endfunction

  function automatic int unsigned choose_residue(int n, int r);
    if (r < 0 || r > n || n >= TBL_DEPTH) return 0;
    return ((fact_tab[n] * inv_fact_tab[r]) % PRIME) * inv_fact_tab[n-r] % PRIME;
  endfunction

  function automatic logic [mcu_pkg::RES_W-1:0] predict_residue(
    logic [2:0] op, logic [31:0] base, logic [31:0] expo,
    logic signed [15:0] n16, logic signed [15:0] r16
  );
    int n;
    int r;
    int unsigned res;
    n = n16;
    r = r16;
    res = 0;
    case (op)
      mcu_pkg::OP_POWER: begin
        res = mod_power(base, expo);
      end
      mcu_pkg::OP_CHOOSE: begin
        res = choose_residue(n, r);
      end
      mcu_pkg::OP_ARRANGE: begin
        if (!(r < 0 || r > n || n >= TBL_DEPTH)) res = fact_tab[n] * inv_fact_tab[n-r] % PRIME;
      end
      mcu_pkg::OP_CATALAN: begin
        if (n >= 0 && 2 * n < TBL_DEPTH)
          res = choose_residue(2 * n, n) * mod_power(n + 1, PRIME - 2) % PRIME;
      end
      mcu_pkg::OP_DERANGEMENT: begin
        if (n >= 0 && n < TBL_DEPTH) res = der_tab[n];
      end
      mcu_pkg::OP_FACTORIAL: begin
        if (n >= 0 && n < TBL_DEPTH) res = fact_tab[n];
      end
      default: begin
        res = 0;
      end
    endcase
    return res[mcu_pkg::RES_W-1:0];
  endfunction

  function automatic request_t random_request();
    request_t req;
    int unsigned pick;
    int nv;
    int rv;
    int jitter;
    pick = $urandom_range(0, 99);
    if (pick < 3) req.op = pick[0] ? OP_SPARE_7 : OP_SPARE_6;
    else req.op = 3'($urandom_range(0, 5));
    req.base = $urandom;
    req.expo = $urandom;
    req.n = 16'($urandom);
    req.r = 16'($urandom);
    req.await_drain = 1'b0;
    if (req.op == mcu_pkg::OP_POWER) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) req.base = $urandom_range(0, 20000);
      else if (pick < 4) req.base = PRIME * $urandom_range(0, 500);
      pick = $urandom_range(0, 9);
      if (pick < 4) req.expo = $urandom_range(0, 64);
      else if (pick < 5) req.expo = 32'($urandom_range(0, 1)) * (PRIME - 2);
    end else if (req.op <= mcu_pkg::OP_FACTORIAL) begin
      pick = $urandom_range(0, 99);
      jitter = $urandom_range(0, 7);
      if (pick < 70) begin
        nv = (req.op == mcu_pkg::OP_CATALAN) ? $urandom_range(0, 530) : $urandom_range(0, 1100);
      end else if (pick < 85) begin
        nv = req.n;
      end else if (pick < 93) begin
        nv = ((req.op == mcu_pkg::OP_CATALAN) ? TBL_DEPTH / 2 : TBL_DEPTH) - 4 + jitter;
      end else begin
        nv = jitter - 4;
      end
      pick = $urandom_range(0, 99);
      jitter = $urandom_range(0, 4);
      if (pick < 60 && nv >= 0) rv = $urandom_range(0, nv);
      else if (pick < 85) rv = nv + jitter - 2;
      else rv = req.r;
      req.n = nv[15:0];
      req.r = rv[15:0];
    end
    return req;
  endfunction

  task automatic add_request(logic [2:0] op, logic [31:0] base, logic [31:0] expo,
                             int n, int r);
    request_t req;
    req.op = op;
    req.base = base;
    req.expo = expo;
    req.n = n[15:0];
    req.r = r[15:0];
    req.await_drain = 1'b0;
    request_q = {request_q, req};
  endtask

  always @(posedge clk) begin
    request_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        residue_expected_q = {residue_expected_q,
                              predict_residue(opcode, power_base, power_exponent,
                                              count_n, choose_r)};
        accepted_count <= accepted_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (request_q.size() != 0 &&
            !(request_q[0].await_drain &&
              ((in_valid && in_ready) || accepted_count != results_seen)) &&
            ((accepted_count >= CALM_FROM && accepted_count < CALM_TO) ||
             $urandom_range(0, 99) >= 23)) begin
          req = request_q.pop_front();
          opcode <= req.op;
          power_base <= req.base;
          power_exponent <= req.expo;
          count_n <= req.n;
          choose_r <= req.r;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic [mcu_pkg::RES_W-1:0] want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_seen >= accepted_count) begin
          errors++;
          $display("%0t: residue expected none, actual %0d", $time, residue);
        end else begin
          want = residue_expected_q.pop_front();
          if (residue !== want) begin
            errors++;
            $display("%0t: residue expected %0d, actual %0d", $time, want, residue);
          end
          results_seen <= results_seen + 1;
        end
      end
      out_ready <= (results_seen >= CALM_FROM && results_seen < CALM_TO) ||
                   $urandom_range(0, 99) >= 23;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    request_t req;
    build_residue_tables();

    add_request(mcu_pkg::OP_POWER, 32'd0, 32'd0, 0, 0);
    add_request(mcu_pkg::OP_POWER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -1, -1);
    add_request(mcu_pkg::OP_POWER, PRIME, 32'd5, 0, 0);
    add_request(mcu_pkg::OP_POWER, 32'd2, PRIME - 2, 0, 0);
    add_request(mcu_pkg::OP_CHOOSE, 0, 0, TBL_DEPTH - 1, 511);
    add_request(mcu_pkg::OP_CHOOSE, 0, 0, TBL_DEPTH - 1, 0);
    add_request(mcu_pkg::OP_CHOOSE, 0, 0, TBL_DEPTH - 1, TBL_DEPTH - 1);
    add_request(mcu_pkg::OP_CHOOSE, 0, 0, 5, 6);
    add_request(mcu_pkg::OP_CHOOSE, 0, 0, 5, -1);
    add_request(mcu_pkg::OP_CHOOSE, 0, 0, TBL_DEPTH, 3);
    add_request(mcu_pkg::OP_CHOOSE, 0, 0, -32768, -32768);
    add_request(mcu_pkg::OP_ARRANGE, 0, 0, TBL_DEPTH - 1, TBL_DEPTH - 1);
    add_request(mcu_pkg::OP_ARRANGE, 0, 0, 10, 11);
    add_request(mcu_pkg::OP_CATALAN, 0, 0, 0, 0);
    add_request(mcu_pkg::OP_CATALAN, 0, 0, TBL_DEPTH / 2 - 1, 0);
    add_request(mcu_pkg::OP_CATALAN, 0, 0, TBL_DEPTH / 2, 0);
    add_request(mcu_pkg::OP_CATALAN, 0, 0, -1, 0);
    add_request(mcu_pkg::OP_DERANGEMENT, 0, 0, 0, 0);
    add_request(mcu_pkg::OP_DERANGEMENT, 0, 0, 1, 0);
    add_request(mcu_pkg::OP_DERANGEMENT, 0, 0, TBL_DEPTH - 1, 0);
    add_request(mcu_pkg::OP_DERANGEMENT, 0, 0, TBL_DEPTH, 0);
    add_request(mcu_pkg::OP_FACTORIAL, 0, 0, TBL_DEPTH - 1, 0);
    add_request(mcu_pkg::OP_FACTORIAL, 0, 0, 32767, 0);
    add_request(OP_SPARE_6, 32'd3, 32'd3, 3, 1);
    add_request(OP_SPARE_7, 32'd3, 32'd3, 3, 1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      req = random_request();
      req.await_drain = (i == 0 || i == 1000 || i == 1600);
      request_q = {request_q, req};
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (request_q.size() != 0 || in_valid || results_seen != accepted_count);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (residue_expected_q.size() != 0) begin
      errors++;
      $display("%0t: residue expected %0d more, actual none", $time,
               residue_expected_q.size());
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mcu_pkg.sv
rtl/mcu_ram.sv
rtl/mcu_modmul.sv
rtl/mcu_datapath.sv
rtl/mcu_ctrl.sv
rtl/modular_combinatorics_unit_core.sv
tb/testbench.sv
